// ===== rtl/core/pfae_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and tables of the anisotropy evaluation core.
package pfae_pkg;

	localparam int GRAD_BITS_DEF    = 16;
	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int VEC_W    = 62;
	localparam int ROT_W    = 34;
	localparam int SCALE_SH = 60;
	localparam int T0_W     = 24;
	localparam int M_W      = 22;
	localparam int ANISO_W  = 20;
	localparam int SLOPE_W  = 23;
	localparam int NUM_GRADS = 5;

	localparam logic signed [ROT_W-1:0] INV_GAIN = ROT_W'(652032874);
	localparam logic signed [ROT_W-1:0] ONE_Q30  = ROT_W'(1073741824);

	typedef enum logic [1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_STRENGTH = 2'd1,
		CFG_ORDER    = 2'd2,
		CFG_ANGLE    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0]     eps;
		logic [15:0]     delta;
		logic [3:0]      order;
		logic [T0_W-1:0] t0;
		logic [M_W-1:0]  m;
	} lane_cfg_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [31:0]             z;
		logic                    zero;
	} vec_beat_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
		logic                    flip;
	} rot_beat_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0:  t = 32'd536870912;
			1:  t = 32'd316933406;
			2:  t = 32'd167458907;
			3:  t = 32'd85004756;
			4:  t = 32'd42667331;
			5:  t = 32'd21354465;
			6:  t = 32'd10679838;
			7:  t = 32'd5340245;
			8:  t = 32'd2670163;
			9:  t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/pfae_vec_cell.sv =====
`timescale 1ns / 1ps
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
module pfae_vec_cell #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  pfae_pkg::vec_beat_t in_beat,
	output pfae_pkg::vec_beat_t out_beat
);

	localparam logic [31:0] ATAN = pfae_pkg::atan_turn(STEP);

	logic signed [pfae_pkg::VEC_W-1:0] xs, ys;
	pfae_pkg::vec_beat_t nxt;

	always_comb begin
		xs = in_beat.x >>> STEP;
		ys = in_beat.y >>> STEP;
		nxt = in_beat;
		if (!in_beat.y[pfae_pkg::VEC_W-1]) begin
			nxt.x = in_beat.x + ys;
			nxt.y = in_beat.y - xs;
			nxt.z = in_beat.z + ATAN;
		end else begin
			nxt.x = in_beat.x - ys;
			nxt.y = in_beat.y + xs;
			nxt.z = in_beat.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		out_beat <= nxt;
	end

endmodule

// ===== rtl/core/pfae_rot_cell.sv =====
`timescale 1ns / 1ps
// One rotating CORDIC cell: a single micro-rotation toward the target phase.
module pfae_rot_cell #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  pfae_pkg::rot_beat_t in_beat,
	output pfae_pkg::rot_beat_t out_beat
);

	localparam logic signed [pfae_pkg::ROT_W-1:0] ATAN =
		pfae_pkg::ROT_W'(pfae_pkg::atan_turn(STEP));

	logic signed [pfae_pkg::ROT_W-1:0] xs, ys;
	pfae_pkg::rot_beat_t nxt;

	always_comb begin
		xs = in_beat.x >>> STEP;
		ys = in_beat.y >>> STEP;
		nxt = in_beat;
		if (!in_beat.z[pfae_pkg::ROT_W-1]) begin
			nxt.x = in_beat.x - ys;
			nxt.y = in_beat.y + xs;
			nxt.z = in_beat.z - ATAN;
		end else begin
			nxt.x = in_beat.x + ys;
			nxt.y = in_beat.y - xs;
			nxt.z = in_beat.z + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		out_beat <= nxt;
	end

endmodule

// ===== rtl/core/pfae_lane.sv =====
`timescale 1ns / 1ps
// One gradient lane: angle chain, phase, cos/sin chain and output scaling.
module pfae_lane #(
	parameter int GRAD_BITS    = pfae_pkg::GRAD_BITS_DEF,
	parameter int ANGLE_BITS   = pfae_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = pfae_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic signed [GRAD_BITS-1:0]          gx,
	input  logic signed [GRAD_BITS-1:0]          gy,
	input  pfae_pkg::lane_cfg_t                  cfg,
	output logic [pfae_pkg::ANISO_W-1:0]         aniso,
	output logic signed [pfae_pkg::SLOPE_W-1:0]  slope
);

	localparam int VW = pfae_pkg::VEC_W;
	localparam int RW = pfae_pkg::ROT_W;
	localparam int SH = pfae_pkg::SCALE_SH - GRAD_BITS;

	pfae_pkg::vec_beat_t vchain [CORDIC_STEPS+1];
	pfae_pkg::rot_beat_t rchain [CORDIC_STEPS+1];

	logic signed [VW-1:0] gx_ext, gy_ext;
	pfae_pkg::vec_beat_t  pre;

	always_comb begin
		gx_ext = {{(VW-GRAD_BITS){gx[GRAD_BITS-1]}}, gx} <<< SH;
		gy_ext = {{(VW-GRAD_BITS){gy[GRAD_BITS-1]}}, gy} <<< SH;
		pre.zero = (gx == '0) && (gy == '0);
		if (gx[GRAD_BITS-1]) begin
			pre.x = -gx_ext;
			pre.y = -gy_ext;
			pre.z = 32'h8000_0000;
		end else begin
			pre.x = gx_ext;
			pre.y = gy_ext;
			pre.z = 32'h0;
		end
	end

	always_ff @(posedge clk) begin
		vchain[0] <= pre;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		pfae_vec_cell #(.STEP(i)) u_cell (
			.clk     (clk),
			.in_beat (vchain[i]),
			.out_beat(vchain[i+1])
		);
	end

	logic [31:0]           z_rnd;
	logic [ANGLE_BITS-1:0] ang, diff;
	logic [ANGLE_BITS+3:0] ph_full;
	logic [ANGLE_BITS-1:0] ph_s2;

	always_comb begin
		z_rnd = vchain[CORDIC_STEPS].z + (32'd1 << (31 - ANGLE_BITS));
		ang = vchain[CORDIC_STEPS].zero ? '0 : z_rnd[31 -: ANGLE_BITS];
		diff = ang - cfg.t0[ANGLE_BITS-1:0];
		ph_full = {{ANGLE_BITS{1'b0}}, cfg.order} * {4'd0, diff};
	end

	always_ff @(posedge clk) begin
		ph_s2 <= ph_full[ANGLE_BITS-1:0];
	end

	logic [31:0]         p, p_adj;
	logic                flip;
	pfae_pkg::rot_beat_t rpre;

	always_comb begin
		p = {ph_s2, {(32-ANGLE_BITS){1'b0}}};
		p_adj = p + 32'h4000_0000;
		flip = p_adj[31];
		p_adj = flip ? (p + 32'h8000_0000) : p;
		rpre.x = pfae_pkg::INV_GAIN;
		rpre.y = '0;
		rpre.z = {{(RW-32){p_adj[31]}}, p_adj};
		rpre.flip = flip;
	end

	always_ff @(posedge clk) begin
		rchain[0] <= rpre;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		pfae_rot_cell #(.STEP(i)) u_cell (
			.clk     (clk),
			.in_beat (rchain[i]),
			.out_beat(rchain[i+1])
		);
	end

	logic signed [RW-1:0] cx, sy, cc, sc;
	logic signed [31:0]   c_s4, s_s4;

	always_comb begin
		cx = rchain[CORDIC_STEPS].flip ? -rchain[CORDIC_STEPS].x : rchain[CORDIC_STEPS].x;
		sy = rchain[CORDIC_STEPS].flip ? -rchain[CORDIC_STEPS].y : rchain[CORDIC_STEPS].y;
		cc = (cx > pfae_pkg::ONE_Q30) ? pfae_pkg::ONE_Q30 :
			(cx < -pfae_pkg::ONE_Q30) ? -pfae_pkg::ONE_Q30 : cx;
		sc = (sy > pfae_pkg::ONE_Q30) ? pfae_pkg::ONE_Q30 :
			(sy < -pfae_pkg::ONE_Q30) ? -pfae_pkg::ONE_Q30 : sy;
	end

	always_ff @(posedge clk) begin
		c_s4 <= cc[31:0];
		s_s4 <= sc[31:0];
	end

	logic signed [48:0] prod, sum;
	logic [47:0]        sum_s5;
	logic [30:0]        smag_s5;
	logic               spos_s5;
	logic [31:0]        s_abs;

	always_comb begin
		prod = $signed({1'b0, cfg.delta}) * c_s4;
		sum = prod + (49'sd1 <<< 46);
		s_abs = s_s4[31] ? -s_s4 : s_s4;
	end

	always_ff @(posedge clk) begin
		sum_s5 <= sum[47:0];
		smag_s5 <= s_abs[30:0];
		spos_s5 <= (s_s4 > 0);
	end

	logic [63:0] a_full;
	logic [52:0] mag_full;
	logic [22:0] mag;

	always_comb begin
		a_full = ({16'd0, sum_s5} * {48'd0, cfg.eps}) + (64'd1 << 43);
		mag_full = ({31'd0, cfg.m} * {22'd0, smag_s5}) + (53'd1 << 29);
		mag = mag_full[52:30];
	end

	always_ff @(posedge clk) begin
		aniso <= a_full[63:44];
		slope <= spos_s5 ? -$signed(mag) : $signed(mag);
	end

endmodule

// ===== rtl/core/phase_field_anisotropy_eval_core.sv =====
`timescale 1ns / 1ps
// Top level of the anisotropy evaluation core: config registers, lanes, strobe line.
//
//  channel  | handshake        | beat
//  ---------+------------------+-----------------------------------------
//  input    | start, busy      | grad_x_* / grad_y_* for five gradients
//  result   | done             | aniso_* / slope_* for five gradients
//  config   | cfg_we           | cfg_index, cfg_data
//
// One beat enters every cycle; busy stays low.
// The path is two chains of CORDIC cells plus six stages: preparation for each
// chain, phase, clamp and the two output multiplies.
// Reset loads the config registers with their defaults and clears the strobe line; data needs none.
// Results appear on done for exactly one cycle; the receiver cannot stall.
module phase_field_anisotropy_eval_core #(
	parameter int GRAD_BITS    = pfae_pkg::GRAD_BITS_DEF,
	parameter int ANGLE_BITS   = pfae_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = pfae_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [GRAD_BITS-1:0] grad_x_center,
	input  logic signed [GRAD_BITS-1:0] grad_y_center,
	input  logic signed [GRAD_BITS-1:0] grad_x_right,
	input  logic signed [GRAD_BITS-1:0] grad_y_right,
	input  logic signed [GRAD_BITS-1:0] grad_x_left,
	input  logic signed [GRAD_BITS-1:0] grad_y_left,
	input  logic signed [GRAD_BITS-1:0] grad_x_top,
	input  logic signed [GRAD_BITS-1:0] grad_y_top,
	input  logic signed [GRAD_BITS-1:0] grad_x_bottom,
	input  logic signed [GRAD_BITS-1:0] grad_y_bottom,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic done,
	output logic [pfae_pkg::ANISO_W-1:0]        aniso_center,
	output logic signed [pfae_pkg::SLOPE_W-1:0] slope_center,
	output logic [pfae_pkg::ANISO_W-1:0]        aniso_right,
	output logic signed [pfae_pkg::SLOPE_W-1:0] slope_right,
	output logic [pfae_pkg::ANISO_W-1:0]        aniso_left,
	output logic signed [pfae_pkg::SLOPE_W-1:0] slope_left,
	output logic [pfae_pkg::ANISO_W-1:0]        aniso_top,
	output logic signed [pfae_pkg::SLOPE_W-1:0] slope_top,
	output logic [pfae_pkg::ANISO_W-1:0]        aniso_bottom,
	output logic signed [pfae_pkg::SLOPE_W-1:0] slope_bottom
);

	localparam int LAT = 2 * CORDIC_STEPS + 6;

	logic [15:0] eps_q, delta_q, angle_q;
	logic [3:0]  order_q;
	logic [pfae_pkg::M_W-1:0] m_q;
	logic [LAT-1:0] vld_q;
	logic [pfae_pkg::T0_W-1:0] t0_al;
	pfae_pkg::lane_cfg_t cfg;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd16384;
			delta_q <= 16'd0;
			order_q <= 4'd4;
			angle_q <= 16'd0;
		end else if (cfg_we) begin
			unique case (pfae_pkg::cfg_idx_t'(cfg_index))
				pfae_pkg::CFG_WIDTH:    eps_q <= cfg_data;
				pfae_pkg::CFG_STRENGTH: delta_q <= cfg_data;
				pfae_pkg::CFG_ORDER:    order_q <= cfg_data[3:0];
				pfae_pkg::CFG_ANGLE:    angle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [35:0] m_full;
	always_comb begin
		m_full = ({20'd0, eps_q} * {20'd0, delta_q}) * {32'd0, order_q} + 36'd8192;
	end

	always_ff @(posedge clk) begin
		m_q <= m_full[35:14];
	end

	if (ANGLE_BITS >= 16) begin : g_t0_up
		logic [31:0] t0w;
		assign t0w = {16'd0, angle_q} << (ANGLE_BITS - 16);
		assign t0_al = t0w[pfae_pkg::T0_W-1:0];
	end else begin : g_t0_dn
		logic [31:0] t0w;
		assign t0w = ({16'd0, angle_q} + (32'd1 << (15 - ANGLE_BITS))) >> (16 - ANGLE_BITS);
		assign t0_al = t0w[pfae_pkg::T0_W-1:0];
	end

	always_comb begin
		cfg.eps = eps_q;
		cfg.delta = delta_q;
		cfg.order = order_q;
		cfg.t0 = t0_al;
		cfg.m = m_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	pfae_lane #(.GRAD_BITS(GRAD_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS))
	u_center (.clk(clk), .gx(grad_x_center), .gy(grad_y_center), .cfg(cfg),
		.aniso(aniso_center), .slope(slope_center));

	pfae_lane #(.GRAD_BITS(GRAD_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS))
	u_right (.clk(clk), .gx(grad_x_right), .gy(grad_y_right), .cfg(cfg),
		.aniso(aniso_right), .slope(slope_right));

	pfae_lane #(.GRAD_BITS(GRAD_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS))
	u_left (.clk(clk), .gx(grad_x_left), .gy(grad_y_left), .cfg(cfg),
		.aniso(aniso_left), .slope(slope_left));

	pfae_lane #(.GRAD_BITS(GRAD_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS))
	u_top (.clk(clk), .gx(grad_x_top), .gy(grad_y_top), .cfg(cfg),
		.aniso(aniso_top), .slope(slope_top));

	pfae_lane #(.GRAD_BITS(GRAD_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS))
	u_bottom (.clk(clk), .gx(grad_x_bottom), .gy(grad_y_bottom), .cfg(cfg),
		.aniso(aniso_bottom), .slope(slope_bottom));

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result strobe missing after fixed latency");

	a_aniso_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (aniso_center <= 20'd524288))
		else $error("anisotropy value out of range");

	a_slope_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(slope_center) >= -23'sd3932160 &&
			$signed(slope_center) <= 23'sd3932160))
		else $error("slope out of range");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the anisotropy core: directed and random gradient beats.
module tb_top;

	localparam int LATENCY = 2 * pfae_pkg::CORDIC_STEPS_DEF + 6;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [15:0] gx[5];
		logic signed [15:0] gy[5];
	} grad_beat_t;

	typedef struct {
		logic [pfae_pkg::ANISO_W-1:0] aniso[5];
		logic [pfae_pkg::SLOPE_W-1:0] slope[5];
	} aniso_beat_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [15:0] gx[5] = '{default: 16'sd0};
	logic signed [15:0] gy[5] = '{default: 16'sd0};
	logic cfg_we = 0;
	logic [1:0] cfg_index = pfae_pkg::CFG_WIDTH;
	logic [15:0] cfg_data = 0;
	logic done;
	logic [pfae_pkg::ANISO_W-1:0] an[5];
	logic signed [pfae_pkg::SLOPE_W-1:0] sl[5];

	grad_beat_t pending_beats[$];
	aniso_beat_t expected_aniso[$];
	int failures = 0;
	int cycles = 0;
	int gap_left = 0;
	int burst_left = 0;
	logic [15:0] eps_r = 16384, delta_r = 0, t0_r = 0;
	logic [3:0] order_r = 4;

	phase_field_anisotropy_eval_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.grad_x_center(gx[0]), .grad_y_center(gy[0]),
		.grad_x_right(gx[1]), .grad_y_right(gy[1]),
		.grad_x_left(gx[2]), .grad_y_left(gy[2]),
		.grad_x_top(gx[3]), .grad_y_top(gy[3]),
		.grad_x_bottom(gx[4]), .grad_y_bottom(gy[4]),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done),
		.aniso_center(an[0]), .slope_center(sl[0]),
		.aniso_right(an[1]), .slope_right(sl[1]),
		.aniso_left(an[2]), .slope_left(sl[2]),
		.aniso_top(an[3]), .slope_top(sl[3]),
		.aniso_bottom(an[4]), .slope_bottom(sl[4])
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint shr_arith(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [15:0] gradient_turns(longint gxv, longint gyv);
		longint x, y, xs, ys;
		logic [31:0] z;
		if (gxv == 0 && gyv == 0) return 16'd0;
		x = gxv <<< 44;
		y = gyv <<< 44;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < pfae_pkg::CORDIC_STEPS_DEF; i++) begin
			xs = shr_arith(x, i);
			ys = shr_arith(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + pfae_pkg::atan_turn(i);
			end else begin
				x = x - ys; y = y + xs; z = z - pfae_pkg::atan_turn(i);
			end
		end
		z = z + 32'h8000;
		return z[31:16];
	endfunction

	function automatic void rotate_phase(input logic [15:0] ph, output longint c,
		output longint s);
		logic [31:0] p;
		logic flip;
		longint x, y, z, xs, ys;
		p = {ph, 16'd0};
		flip = 0;
		x = 652032874;
		y = 0;
		if (((p + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			p = p + 32'h8000_0000;
			flip = 1;
		end
		z = longint'(signed'(p));
		for (int i = 0; i < pfae_pkg::CORDIC_STEPS_DEF; i++) begin
			xs = shr_arith(x, i);
			ys = shr_arith(y, i);
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - longint'(pfae_pkg::atan_turn(i));
			end else begin
				x = x + ys; y = y - xs; z = z + longint'(pfae_pkg::atan_turn(i));
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x > 1073741824 ? 1073741824 : (x < -1073741824 ? -1073741824 : x);
		s = y > 1073741824 ? 1073741824 : (y < -1073741824 ? -1073741824 : y);
	endfunction

	function automatic aniso_beat_t predict_aniso(grad_beat_t b);
		aniso_beat_t r;
		logic [15:0] ang, ph;
		longint c, s, sm, mag, sv;
		logic [63:0] sum, m;
		for (int k = 0; k < 5; k++) begin
			ang = gradient_turns(longint'(b.gx[k]), longint'(b.gy[k]));
			ph = 16'(order_r * 16'(ang - t0_r));
			rotate_phase(ph, c, s);
			sum = 64'(longint'(1) <<< 46) + 64'(longint'(delta_r) * c);
			r.aniso[k] = pfae_pkg::ANISO_W'((sum * 64'(eps_r) + (64'd1 << 43)) >> 44);
			m = (64'(eps_r) * 64'(delta_r) * 64'(order_r) + 64'd8192) >> 14;
			sm = s < 0 ? -s : s;
			mag = longint'((m * 64'(sm) + (64'd1 << 29)) >> 30);
			sv = s > 0 ? -mag : mag;
			r.slope[k] = pfae_pkg::SLOPE_W'(sv);
		end
		return r;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				if (burst_left > 0) burst_left--;
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 0;
			end else if (pending_beats.size() > 0 && (!start || !busy)) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end
				if (gap_left > 0) begin
					start <= 0;
				end else begin
					for (int k = 0; k < 5; k++) begin
						gx[k] <= pending_beats[0].gx[k];
						gy[k] <= pending_beats[0].gy[k];
					end
					expected_aniso.push_back(predict_aniso(pending_beats[0]));
					pending_beats.pop_front();
					start <= 1;
				end
			end else if (!start || !busy) begin
				start <= 0;
			end
		end
	end

	always @(posedge clk) begin
		aniso_beat_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (arst_n && done) begin
			if (expected_aniso.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				failures++;
			end else begin
				e = expected_aniso.pop_front();
				for (int k = 0; k < 5; k++) begin
					if (an[k] !== e.aniso[k]) begin
						$display("%0t: aniso[%0d] expected %0d actual %0d",
							$time, k, e.aniso[k], an[k]);
						failures++;
					end
					if (sl[k] !== e.slope[k]) begin
						$display("%0t: slope[%0d] expected %0d actual %0d",
							$time, k, $signed(e.slope[k]), sl[k]);
						failures++;
					end
				end
			end
		end
	end

	task automatic write_reg(pfae_pkg::cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			pfae_pkg::CFG_WIDTH: eps_r = val;
			pfae_pkg::CFG_STRENGTH: delta_r = val;
			pfae_pkg::CFG_ORDER: order_r = val[3:0];
			default: t0_r = val;
		endcase
	endtask

	task automatic push_grad(logic signed [15:0] x, logic signed [15:0] y);
		grad_beat_t b;
		for (int k = 0; k < 5; k++) begin
			b.gx[k] = (k == 0) ? x : 16'($urandom);
			b.gy[k] = (k == 0) ? y : 16'($urandom);
		end
		b.gx[4] = y;
		b.gy[4] = x;
		pending_beats.push_back(b);
	endtask

	task automatic push_random(int n);
		grad_beat_t b;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 5; k++) begin
				case ($urandom_range(0, 3))
					0: b.gx[k] = 16'($signed($urandom_range(0, 64)) - 32);
					default: b.gx[k] = 16'($urandom);
				endcase
				b.gy[k] = ($urandom_range(0, 7) == 0) ? 16'sd0 : 16'($urandom);
				if ($urandom_range(0, 15) == 0) b.gx[k] = 0;
			end
			pending_beats.push_back(b);
		end
	endtask

	task automatic drain;
		while (pending_beats.size() > 0 || expected_aniso.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		push_grad(0, 0);
		push_grad(16'sh7fff, 0);
		push_grad(-16'sh8000, 0);
		push_grad(0, 16'sh7fff);
		push_grad(0, -16'sh8000);
		push_grad(-16'sh8000, -16'sh8000);
		push_grad(16'sh7fff, 16'sh7fff);
		push_grad(-1, 1);
		push_grad(1, -1);
		push_grad(-16'sh8000, 16'sh7fff);
		drain();
		write_reg(pfae_pkg::CFG_STRENGTH, 16'hffff);
		write_reg(pfae_pkg::CFG_WIDTH, 16'hffff);
		write_reg(pfae_pkg::CFG_ORDER, 16'd15);
		write_reg(pfae_pkg::CFG_ANGLE, 16'hffff);
		push_grad(0, 0);
		push_grad(-16'sh8000, 16'sh7fff);
		push_grad(16'sh7fff, -16'sh8000);
		push_random(100);
		drain();
		write_reg(pfae_pkg::CFG_ORDER, 16'd0);
		write_reg(pfae_pkg::CFG_WIDTH, 16'd0);
		push_grad(5, 7);
		push_random(60);
		drain();
		write_reg(pfae_pkg::CFG_WIDTH, 16'd16384);
		write_reg(pfae_pkg::CFG_STRENGTH, 16'd0);
		write_reg(pfae_pkg::CFG_ORDER, 16'd1);
		write_reg(pfae_pkg::CFG_ANGLE, 16'd0);
		push_random(80);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(pfae_pkg::CFG_WIDTH, 16'($urandom));
			write_reg(pfae_pkg::CFG_STRENGTH, 16'($urandom));
			write_reg(pfae_pkg::CFG_ORDER, 16'($urandom_range(0, 15)));
			write_reg(pfae_pkg::CFG_ANGLE, 16'($urandom));
			push_random(75);
			drain();
		end
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/pfae_pkg.sv
rtl/core/pfae_vec_cell.sv
rtl/core/pfae_rot_cell.sv
rtl/core/pfae_lane.sv
rtl/core/phase_field_anisotropy_eval_core.sv
tb/tb_top.sv
